/* rtl/cec_pkg.sv */
// ----------------------------------------------------------------------------
// cec_pkg
// Shared constants and types for the circular easing curve pipeline.
// ----------------------------------------------------------------------------
package cec_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned ADDR_WIDTH     = 3;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_INOUT = 2'd2,
    MODE_SPARE = 2'd3
  } ease_mode_t;

  typedef enum logic [ADDR_WIDTH-1:0] {
    REG_DURATION = 3'd0,
    REG_MODE     = 3'd4
  } reg_addr_t;

endpackage

/* rtl/cec_if.sv */
// ----------------------------------------------------------------------------
// cec_in_if / cec_out_if
// Valid/ready channels carrying time words and eased value words.
// ----------------------------------------------------------------------------
interface cec_in_if #(parameter int unsigned TIME_WIDTH = cec_pkg::TIME_WIDTH_DEF);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] elapsed_ticks;
  modport source (output valid, output elapsed_ticks, input ready);
  modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface cec_out_if #(parameter int unsigned FRAC_BITS = cec_pkg::FRAC_BITS_DEF);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] eased_value;
  logic               clamped;
  modport source (output valid, output eased_value, output clamped, input ready);
  modport sink   (input valid, input eased_value, input clamped, output ready);
endinterface

/* rtl/cec_div_cell.sv */
// ----------------------------------------------------------------------------
// cec_div_cell
// One restoring division step: yields one quotient bit per cell.
// ----------------------------------------------------------------------------
module cec_div_cell #(
  parameter int unsigned TW = cec_pkg::TIME_WIDTH_DEF,
  parameter int unsigned QW = cec_pkg::FRAC_BITS_DEF + 2,
  parameter int unsigned PW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [TW:0]   in_rem,
  input  logic [TW-1:0] in_div,
  input  logic [QW-1:0] in_quo,
  input  logic [PW-1:0] in_pass,
  output logic          out_valid,
  output logic [TW:0]   out_rem,
  output logic [TW-1:0] out_div,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pass
);
  logic [TW+1:0] shifted;
  logic [TW+1:0] diff;
  logic          take;

  always_comb begin
    shifted = {in_rem, 1'b0};
    diff    = shifted - {2'b00, in_div};
    take    = shifted >= {2'b00, in_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= take ? diff[TW:0] : shifted[TW:0];
      out_div  <= in_div;
      out_quo  <= {in_quo[QW-2:0], take};
      out_pass <= in_pass;
    end
  end
endmodule

/* rtl/cec_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// cec_sqrt_cell
// One digit-by-digit square root step: yields one root bit per cell.
// ----------------------------------------------------------------------------
module cec_sqrt_cell #(
  parameter int unsigned RW = cec_pkg::FRAC_BITS_DEF + 1,
  parameter int unsigned PW = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] in_rad,
  input  logic [RW+1:0]   in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [PW-1:0]   in_pass,
  output logic            out_valid,
  output logic [2*RW-1:0] out_rad,
  output logic [RW+1:0]   out_rem,
  output logic [RW-1:0]   out_root,
  output logic [PW-1:0]   out_pass
);
  logic [RW+1:0] cur;
  logic [RW+1:0] trial;
  logic          take;

  // bring down the next two radicand bits, try root*4+1
  always_comb begin
    cur   = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
    trial = {in_root, 2'b01};
    take  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= {in_rad[2*RW-3:0], 2'b00};
      out_rem  <= take ? cur - trial : cur;
      out_root <= {in_root[RW-2:0], take};
      out_pass <= in_pass;
    end
  end
endmodule

/* rtl/circular_easing_curve_top.sv */
// ----------------------------------------------------------------------------
// circular_easing_curve_top
// Circular easing pipeline: divider chain, squaring stage, root chain.
//
//   port      dir   handshake       word
//   in_ch     sink  valid/ready     elapsed_ticks
//   out_ch    src   valid/ready     eased_value, clamped
//   apb       slave psel/penable    duration_ticks @0, ease_mode @4
//
// one word accepted per cycle while not stalled; stages: FRAC_BITS+2 divider
// cells, one square stage, FRAC_BITS+1 root cells, one output stage.
// the whole row advances together and freezes while the output word is
// held with ready low; rst is synchronous and clears all valid bits.
// ----------------------------------------------------------------------------
module circular_easing_curve_top #(
  parameter int unsigned TIME_WIDTH = cec_pkg::TIME_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = cec_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  cec_in_if.sink                        in_ch,
  cec_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cec_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned QW = FRAC_BITS + 2;   // quotient of e*2^(F+2)/d
  localparam int unsigned RW = FRAC_BITS + 1;   // root width
  localparam int unsigned PW = 3;               // mode(2), clamped
  localparam int unsigned SPW = PW + 1;         // mode(2), upper half, clamped
  localparam int unsigned ND = QW;
  localparam int unsigned NS = RW;

  logic [15:0] duration_ticks;
  logic [1:0]  ease_mode;
  logic        adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ticks <= 16'd1;
      ease_mode      <= 2'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        cec_pkg::REG_DURATION: duration_ticks <= pwdata[15:0];
        cec_pkg::REG_MODE:     ease_mode      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pready = 1'b1;
    unique case (paddr)
      cec_pkg::REG_DURATION: prdata = {16'd0, duration_ticks};
      cec_pkg::REG_MODE:     prdata = {30'd0, ease_mode};
      default:               prdata = 32'd0;
    endcase
  end

  // front: clamp, pick mode
  logic [TW-1:0] dur_eff;
  logic [TW-1:0] e_eff;
  logic          clamp_f;
  logic [1:0]    mode_eff;

  always_comb begin
    dur_eff = (TW >= 16) ? TW'(duration_ticks) : duration_ticks[TW-1:0];
    if (dur_eff == '0) dur_eff = TW'(1);
    clamp_f  = in_ch.elapsed_ticks > dur_eff;
    e_eff    = clamp_f ? dur_eff : in_ch.elapsed_ticks;
    mode_eff = (ease_mode == cec_pkg::MODE_SPARE) ? cec_pkg::MODE_INOUT : ease_mode;
  end

  logic          out_valid;
  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // divider chain: dividend e * 2^(F+2); the remainder is seeded with e
  // itself, so only zeros are shifted in, and e rides along
  logic          dv [ND+1];
  logic [TW:0]   dr [ND+1];
  logic [TW-1:0] dd [ND+1];
  logic [QW-1:0] dq [ND+1];
  logic [PW+TW-1:0] dp [ND+1];

  // start from remainder e with quotient bits F+1..0 left: since e<=d the
  // upper quotient bits are zero unless e==d
  assign dv[0] = in_ch.valid;
  assign dr[0] = {1'b0, e_eff};
  assign dd[0] = dur_eff;
  assign dq[0] = '0;
  assign dp[0] = {mode_eff, clamp_f, e_eff};

  // the first step gives bit F+1 of floor(e*2^(F+2)/d) as the quotient top
  for (genvar i = 0; i < ND; i++) begin : g_div
    cec_div_cell #(.TW(TW), .QW(QW), .PW(PW+TW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(dv[i]), .in_rem(dr[i]), .in_div(dd[i]), .in_quo(dq[i]),
      .in_pass(dp[i]),
      .out_valid(dv[i+1]), .out_rem(dr[i+1]), .out_div(dd[i+1]),
      .out_quo(dq[i+1]), .out_pass(dp[i+1])
    );
  end

  // the loop computes floor(e*2^QW/d) with e<d or e==d; remainder seeded
  // with e then shifted QW times gives floor(e*2^QW/d) truncated to QW bits,
  // so e==d would wrap: correct that case explicitly
  logic [QW:0] p2_full;
  logic [1:0]  mode_d;
  logic        clamp_d;
  logic [TW-1:0] e_d;
  always_comb begin
    {mode_d, clamp_d, e_d} = dp[ND];
    p2_full = (e_d == dd[ND]) ? (QW+1)'(1) << QW : {1'b0, dq[ND]};
  end

  // square stage: p2_full = floor(e*2^(F+2)/d); P2 = p2>>1, P = p2>>2
  localparam logic [RW:0] ONE = (RW+1)'(1) << FRAC_BITS;
  logic [RW:0]   x_sel;
  logic          upper_sel;
  logic [RW:0]   pp, pp2;
  always_comb begin
    pp  = {1'b0, p2_full[QW:2]};
    pp2 = p2_full[QW:1];
    upper_sel = 1'b0;
    unique case (mode_d)
      cec_pkg::MODE_IN:  x_sel = pp;
      cec_pkg::MODE_OUT: x_sel = ONE - pp;
      default: begin
        if (pp2 < ONE) begin
          x_sel = pp2;
        end else begin
          x_sel     = (ONE << 1) - pp2;
          upper_sel = 1'b1;
        end
      end
    endcase
  end

  logic            sq_valid;
  logic [2*RW-1:0] sq_rad;
  logic [SPW-1:0]  sq_pass;
  logic [2*RW+1:0] one_sq;
  logic [2*RW+1:0] x_sq;
  always_comb begin
    one_sq = (2*RW+2)'(1) << (2*FRAC_BITS);
    x_sq   = (2*RW+2)'(x_sel) * (2*RW+2)'(x_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (adv) begin
      sq_valid <= dv[ND];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rad  <= (2*RW)'(one_sq - x_sq);
      sq_pass <= {mode_d, upper_sel, clamp_d};
    end
  end

  // root chain
  logic            sv [NS+1];
  logic [2*RW-1:0] sr [NS+1];
  logic [RW+1:0]   sm [NS+1];
  logic [RW-1:0]   so [NS+1];
  logic [SPW-1:0]  sp [NS+1];

  assign sv[0] = sq_valid;
  assign sr[0] = sq_rad;
  assign sm[0] = '0;
  assign so[0] = '0;
  assign sp[0] = sq_pass;

  for (genvar j = 0; j < NS; j++) begin : g_root
    cec_sqrt_cell #(.RW(RW), .PW(SPW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(sv[j]), .in_rad(sr[j]), .in_rem(sm[j]), .in_root(so[j]),
      .in_pass(sp[j]),
      .out_valid(sv[j+1]), .out_rad(sr[j+1]), .out_rem(sm[j+1]),
      .out_root(so[j+1]), .out_pass(sp[j+1])
    );
  end

  // finish: mode bit kept is ease_mode[1] (in-out), [0] is ease out
  logic [RW:0] root_w;
  logic [RW:0] val;
  logic        inout_f;
  always_comb begin
    root_w  = {1'b0, so[NS]};
    inout_f = sp[NS][3];
    if (!inout_f) begin
      val = sp[NS][2] ? root_w : ONE - root_w;
    end else begin
      val = sp[NS][1] ? (ONE + root_w) >> 1 : (ONE - root_w) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= sv[NS];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.eased_value <= val[RW-1:0];
      out_ch.clamped     <= sp[NS][0];
    end
  end
  assign out_ch.valid = out_valid;

endmodule
